// ----- rtl/core/stj_pkg.sv -----
// ----------------------------------------------------------------------------
// stj_pkg
// Shared types and constants of the series tuple join: field widths, command
// and result codes, and the words that pass between front, back and queue.
// ----------------------------------------------------------------------------
package stj_pkg;

    localparam int OP_W    = 2;
    localparam int ID_W    = 64;
    localparam int TS_W    = 64;
    localparam int VAL_W   = 64;
    localparam int SLOT_W  = 6;
    localparam int MASK_W  = 58;
    localparam int CNT_W   = 6;
    localparam int KIND_W  = 2;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 1;

    localparam int MAX_SERIES_DEF = 58;
    localparam logic [SLOT_W-1:0] NUM_SERIES_RST = SLOT_W'(1);

    // Input queue and result queue depths
    localparam int IQ_DEPTH = 2;
    localparam int RQ_DEPTH = 4;

    // Input op codes
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SERIES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_ID     = 1'b1;

    typedef enum logic [1:0] {
        CMD_SAMPLE,
        CMD_WRITE,
        CMD_FLUSH
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_VALUE  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_DROP   = 2'd2
    } kind_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [ID_W-1:0]   series_id;
        logic [TS_W-1:0]   timestamp;
        logic [VAL_W-1:0]  value_bits;
        logic [SLOT_W-1:0] slot;
    } item_t;

    // Head of the input queue as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } fq_t;

    typedef struct packed {
        kind_t             kind;
        logic [TS_W-1:0]   time_out;
        logic [ID_W-1:0]   id_out;
        logic [VAL_W-1:0]  value_out;
        logic [SLOT_W-1:0] slot_out;
        logic [MASK_W-1:0] presence_mask;
        logic [CNT_W-1:0]  value_count;
        logic              last;
    } res_t;

endpackage

// ----- rtl/core/series_tuple_join.sv -----
// Back end steps: a slot write is done as the item is taken; a flush emits a header when a tuple is held;
// a sample scans slots and emits its results, and when it closes the tuple it also emits the
// header and rescans from slot 0 (up to 2 * num_series slots scanned).
// Throughput: one item at a time in the back end, one slot read a cycle; a 2-word
// input queue and a 4-word result queue decouple it from both sides.
// Reset clears queues, tuple state and registers; the slot id table is not cleared.
// ----------------------------------------------------------------------------
// series_tuple_join
// Groups merged time-series samples into tuples over a list of series slots.
// ----------------------------------------------------------------------------
module series_tuple_join #(
    parameter int MAX_SERIES = stj_pkg::MAX_SERIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [stj_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stj_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [stj_pkg::OP_W-1:0]          op,
    input  logic [stj_pkg::ID_W-1:0]          series_id,
    input  logic [stj_pkg::TS_W-1:0]          timestamp,
    input  logic [stj_pkg::VAL_W-1:0]         value_bits,
    input  logic [stj_pkg::SLOT_W-1:0]        slot,
    output logic                              empty,
    input  logic                              pop,
    output logic [stj_pkg::KIND_W-1:0]        kind,
    output logic [stj_pkg::TS_W-1:0]          time_out,
    output logic [stj_pkg::ID_W-1:0]          id_out,
    output logic [stj_pkg::VAL_W-1:0]         value_out,
    output logic [stj_pkg::SLOT_W-1:0]        slot_out,
    output logic [stj_pkg::MASK_W-1:0]        presence_mask,
    output logic [stj_pkg::CNT_W-1:0]         value_count,
    output logic                              last
);

    stj_pkg::fq_t   head;
    logic           take;
    logic           res_push;
    stj_pkg::res_t  res_word;
    logic           res_full;
    stj_pkg::res_t  out_word;

    stj_front #(
        .MAX_SERIES (MAX_SERIES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .op         (op),
        .series_id  (series_id),
        .timestamp  (timestamp),
        .value_bits (value_bits),
        .slot       (slot),
        .head       (head),
        .take       (take)
    );

    stj_back #(
        .MAX_SERIES (MAX_SERIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head       (head),
        .take       (take),
        .res_push   (res_push),
        .res_word   (res_word),
        .res_full   (res_full)
    );

    stj_res_fifo u_res_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (res_push),
        .wr_word    (res_word),
        .full       (res_full),
        .empty      (empty),
        .pop        (pop),
        .rd_word    (out_word)
    );

    assign kind          = out_word.kind;
    assign time_out      = out_word.time_out;
    assign id_out        = out_word.id_out;
    assign value_out     = out_word.value_out;
    assign slot_out      = out_word.slot_out;
    assign presence_mask = out_word.presence_mask;
    assign value_count   = out_word.value_count;
    assign last          = out_word.last;

    // Back end must never write into a full result queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written while queue full");

    // Back end takes only a valid queued command
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> head.valid)
        else $error("command taken from empty input queue");

    // A closed tuple always holds at least one value
    a_header_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_word.kind == stj_pkg::KIND_HEADER)
            |-> (res_word.value_count != '0) && (res_word.presence_mask != '0))
        else $error("empty tuple header emitted");

endmodule

// ----- rtl/core/stj_front.sv -----
// ----------------------------------------------------------------------------
// stj_front
// Accepts input words, decodes the op and drops words that do nothing
// (unused op, slot write out of range); keeps the rest in a short queue.
// ----------------------------------------------------------------------------
module stj_front #(
    parameter int MAX_SERIES = stj_pkg::MAX_SERIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [stj_pkg::OP_W-1:0]        op,
    input  logic [stj_pkg::ID_W-1:0]        series_id,
    input  logic [stj_pkg::TS_W-1:0]        timestamp,
    input  logic [stj_pkg::VAL_W-1:0]       value_bits,
    input  logic [stj_pkg::SLOT_W-1:0]      slot,
    output stj_pkg::fq_t                    head,
    input  logic                            take
);

    localparam int DEPTH = stj_pkg::IQ_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [stj_pkg::SLOT_W-1:0] MAX_N = stj_pkg::SLOT_W'(MAX_SERIES);

    stj_pkg::item_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    stj_pkg::item_t    item_in;
    logic              keep;
    logic              enq;

    // Classify the incoming word
    always_comb
    begin
        item_in.series_id  = series_id;
        item_in.timestamp  = timestamp;
        item_in.value_bits = value_bits;
        item_in.slot       = slot;
        item_in.cmd        = stj_pkg::CMD_SAMPLE;
        keep               = 1'b0;
        case (op)
            stj_pkg::OP_SAMPLE:
            begin
                item_in.cmd = stj_pkg::CMD_SAMPLE;
                keep        = 1'b1;
            end
            stj_pkg::OP_WRITE:
            begin
                item_in.cmd = stj_pkg::CMD_WRITE;
                keep        = (slot < MAX_N);
            end
            stj_pkg::OP_FLUSH:
            begin
                item_in.cmd = stj_pkg::CMD_FLUSH;
                keep        = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign full = (count_reg == CNT_W'(DEPTH));
    assign enq  = push && !full && keep;

    assign head.valid = (count_reg != '0);
    assign head.item  = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (enq)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (take)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (enq && !take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (take && !enq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            entry_reg[wptr_reg] <= item_in;
        end
    end

endmodule

// ----- rtl/core/stj_back.sv -----
// ----------------------------------------------------------------------------
// stj_back
// Executes queued commands: owns the slot id table, scans it one slot a
// cycle, tracks the pending tuple and emits values, headers and drops.
// ----------------------------------------------------------------------------
module stj_back #(
    parameter int MAX_SERIES = stj_pkg::MAX_SERIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [stj_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stj_pkg::CFG_W-1:0]        cfg_data,
    input  stj_pkg::fq_t                     head,
    output logic                             take,
    output logic                             res_push,
    output stj_pkg::res_t                    res_word,
    input  logic                             res_full
);

    localparam int AW = (MAX_SERIES > 1) ? $clog2(MAX_SERIES) : 1;
    localparam int SW = stj_pkg::SLOT_W;
    localparam logic [SW-1:0] MAX_N = SW'(MAX_SERIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_VAL,
        S_HDR,
        S_DROP
    } state_t;

    state_t                         state_reg, state_next;
    logic [SW-1:0]                  num_series_reg, num_series_next;
    logic [stj_pkg::ID_W-1:0]       out_id_reg, out_id_next;
    stj_pkg::item_t                 cur_reg, cur_next;
    logic [SW-1:0]                  scan_ptr_reg, scan_ptr_next;
    logic                           pend_reg, pend_next;
    logic [SW-1:0]                  pend_idx_reg, pend_idx_next;
    logic [SW-1:0]                  match_reg, match_next;
    logic                           rescan_reg, rescan_next;
    logic [SW-1:0]                  next_slot_reg, next_slot_next;
    logic [stj_pkg::CNT_W-1:0]      held_count_reg, held_count_next;
    logic [stj_pkg::MASK_W-1:0]     held_mask_reg, held_mask_next;
    logic [stj_pkg::TS_W-1:0]       tuple_time_reg, tuple_time_next;

    logic [stj_pkg::ID_W-1:0]       slot_mem [MAX_SERIES];
    logic [stj_pkg::ID_W-1:0]       rd_data_reg;
    logic                           mem_we;
    logic                           rd_en;

    logic [SW-1:0]                  n_used;
    logic                           hit;
    logic                           more;
    logic                           held;
    logic [SW-1:0]                  slot_inc;
    logic                           close_after;

    assign n_used      = (num_series_reg > MAX_N) ? MAX_N : num_series_reg;
    assign hit         = pend_reg && (rd_data_reg == cur_reg.series_id);
    assign more        = (scan_ptr_reg < n_used);
    assign held        = (held_count_reg != '0);
    assign slot_inc    = match_reg + 1'b1;
    assign close_after = (slot_inc >= n_used);

    always_comb
    begin
        state_next      = state_reg;
        num_series_next = num_series_reg;
        out_id_next     = out_id_reg;
        cur_next        = cur_reg;
        scan_ptr_next   = scan_ptr_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        match_next      = match_reg;
        rescan_next     = rescan_reg;
        next_slot_next  = next_slot_reg;
        held_count_next = held_count_reg;
        held_mask_next  = held_mask_reg;
        tuple_time_next = tuple_time_reg;
        take            = 1'b0;
        mem_we          = 1'b0;
        rd_en           = 1'b0;
        res_push        = 1'b0;
        res_word        = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                stj_pkg::CFG_NUM_SERIES: num_series_next = cfg_data[SW-1:0];
                stj_pkg::CFG_OUT_ID:     out_id_next     = cfg_data;
                default:                 ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    take     = 1'b1;
                    cur_next = head.item;
                    case (head.item.cmd)
                        stj_pkg::CMD_WRITE:
                        begin
                            mem_we = 1'b1;
                        end
                        stj_pkg::CMD_FLUSH:
                        begin
                            if (held)
                            begin
                                rescan_next = 1'b0;
                                state_next  = S_HDR;
                            end
                        end
                        stj_pkg::CMD_SAMPLE:
                        begin
                            scan_ptr_next = next_slot_reg;
                            pend_next     = 1'b0;
                            state_next    = S_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (!hit && more)
                begin
                    // Issue the next slot read; the compare follows in the next cycle
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = scan_ptr_reg;
                    scan_ptr_next = scan_ptr_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (held && (!hit || cur_reg.timestamp != tuple_time_reg))
                    begin
                        // Close the pending tuple, then rescan from slot zero
                        rescan_next = 1'b1;
                        state_next  = S_HDR;
                    end
                    else if (!hit)
                    begin
                        state_next = S_DROP;
                    end
                    else
                    begin
                        match_next = pend_idx_reg;
                        state_next = S_VAL;
                    end
                end
            end

            S_VAL:
            begin
                if (!res_full)
                begin
                    res_push           = 1'b1;
                    res_word.kind      = stj_pkg::KIND_VALUE;
                    res_word.time_out  = held ? tuple_time_reg : cur_reg.timestamp;
                    res_word.id_out    = cur_reg.series_id;
                    res_word.value_out = cur_reg.value_bits;
                    res_word.slot_out  = match_reg;
                    res_word.last      = !close_after;
                    if (!held)
                    begin
                        tuple_time_next = cur_reg.timestamp;
                    end
                    held_mask_next  = held_mask_reg
                                    | (stj_pkg::MASK_W'(1) << match_reg);
                    held_count_next = held_count_reg + 1'b1;
                    next_slot_next  = slot_inc;
                    if (close_after)
                    begin
                        rescan_next = 1'b0;
                        state_next  = S_HDR;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_HDR:
            begin
                if (!res_full)
                begin
                    res_push               = 1'b1;
                    res_word.kind          = stj_pkg::KIND_HEADER;
                    res_word.time_out      = tuple_time_reg;
                    res_word.id_out        = out_id_reg;
                    res_word.presence_mask = held_mask_reg;
                    res_word.value_count   = held_count_reg;
                    res_word.last          = !rescan_reg;
                    held_count_next        = '0;
                    held_mask_next         = '0;
                    next_slot_next         = '0;
                    if (rescan_reg)
                    begin
                        rescan_next   = 1'b0;
                        scan_ptr_next = '0;
                        pend_next     = 1'b0;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_DROP:
            begin
                if (!res_full)
                begin
                    res_push          = 1'b1;
                    res_word.kind     = stj_pkg::KIND_DROP;
                    res_word.time_out = cur_reg.timestamp;
                    res_word.id_out   = cur_reg.series_id;
                    res_word.last     = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            num_series_reg <= stj_pkg::NUM_SERIES_RST;
            out_id_reg     <= '0;
            scan_ptr_reg   <= '0;
            pend_reg       <= 1'b0;
            rescan_reg     <= 1'b0;
            next_slot_reg  <= '0;
            held_count_reg <= '0;
            held_mask_reg  <= '0;
            tuple_time_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            num_series_reg <= num_series_next;
            out_id_reg     <= out_id_next;
            scan_ptr_reg   <= scan_ptr_next;
            pend_reg       <= pend_next;
            rescan_reg     <= rescan_next;
            next_slot_reg  <= next_slot_next;
            held_count_reg <= held_count_next;
            held_mask_reg  <= held_mask_next;
            tuple_time_reg <= tuple_time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        pend_idx_reg <= pend_idx_next;
        match_reg    <= match_next;
    end

    // Slot id table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[head.item.slot[AW-1:0]] <= head.item.series_id;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[scan_ptr_reg[AW-1:0]];
        end
    end

endmodule

// ----- rtl/core/stj_res_fifo.sv -----
// ----------------------------------------------------------------------------
// stj_res_fifo
// Result queue between the back end and the output ports.
// ----------------------------------------------------------------------------
module stj_res_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  stj_pkg::res_t  wr_word,
    output logic           full,
    output logic           empty,
    input  logic           pop,
    output stj_pkg::res_t  rd_word
);

    localparam int DEPTH = stj_pkg::RQ_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    stj_pkg::res_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              enq;
    logic              deq;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign enq     = wr && !full;
    assign deq     = pop && !empty;
    assign rd_word = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (enq)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (deq)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (enq && !deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (deq && !enq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            entry_reg[wptr_reg] <= wr_word;
        end
    end

endmodule

// ----- tb/tuple_join_checker.sv -----
// ----------------------------------------------------------------------------
// tuple_join_checker
// Watches the register port and both queue sides of series_tuple_join, keeps
// its own copy of the slot table and tuple state, predicts the result words
// of every accepted input word and compares them in order with what pops out.
// ----------------------------------------------------------------------------
module tuple_join_checker
    import stj_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 push,
    input  logic                 full,
    input  logic [OP_W-1:0]      op,
    input  logic [ID_W-1:0]      series_id,
    input  logic [TS_W-1:0]      timestamp,
    input  logic [VAL_W-1:0]     value_bits,
    input  logic [SLOT_W-1:0]    slot,
    input  logic                 empty,
    input  logic                 pop,
    input  logic [KIND_W-1:0]    kind,
    input  logic [TS_W-1:0]      time_out,
    input  logic [ID_W-1:0]      id_out,
    input  logic [VAL_W-1:0]     value_out,
    input  logic [SLOT_W-1:0]    slot_out,
    input  logic [MASK_W-1:0]    presence_mask,
    input  logic [CNT_W-1:0]     value_count,
    input  logic                 last,
    output int                   fail_count,
    output int                   pending_words,
    output int                   value_words,
    output int                   header_words,
    output int                   drop_words
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = MAX_SERIES_DEF;
    localparam int SHOW_LIMIT = 10;

    logic [ID_W-1:0]   slot_ids [SLOTS];
    logic [SLOT_W-1:0] num_series;
    logic [ID_W-1:0]   out_series_id;
    int                scan_pos;
    logic [CNT_W-1:0]  held_count;
    logic [MASK_W-1:0] held_mask;
    logic [TS_W-1:0]   tuple_time;
    res_t              expected_words [$];

    function automatic int slots_in_use();
        return (num_series > SLOTS) ? SLOTS : int'(num_series);
    endfunction

    function automatic int find_slot(input int from, input logic [ID_W-1:0] id);
        for (int s = from; s < slots_in_use(); s++)
            if (slot_ids[s] == id)
                return s;
        return SLOTS;
    endfunction

    function automatic res_t make_word(input kind_t kd, input logic [TS_W-1:0] t,
                                       input logic [ID_W-1:0] id,
                                       input logic [VAL_W-1:0] v,
                                       input logic [SLOT_W-1:0] sl,
                                       input logic [MASK_W-1:0] m,
                                       input logic [CNT_W-1:0] c);
        res_t w;
        w.kind          = kd;
        w.time_out      = t;
        w.id_out        = id;
        w.value_out     = v;
        w.slot_out      = sl;
        w.presence_mask = m;
        w.value_count   = c;
        w.last          = 1'b0;
        return w;
    endfunction

    // build the header of the pending tuple and start over
    function automatic res_t close_tuple();
        res_t w;
        w = make_word(KIND_HEADER, tuple_time, out_series_id, '0, '0, held_mask, held_count);
        scan_pos   = 0;
        held_count = '0;
        held_mask  = '0;
        return w;
    endfunction

    task automatic predict_tuple_words(input logic [OP_W-1:0] o, input logic [ID_W-1:0] id,
                                       input logic [TS_W-1:0] ts,
                                       input logic [VAL_W-1:0] val,
                                       input logic [SLOT_W-1:0] sl);
        res_t words [3];
        int   k;
        int   hit;
        k = 0;
        if (o == OP_WRITE) begin
            if (sl < SLOTS)
                slot_ids[sl] = id;
        end
        else if (o == OP_FLUSH) begin
            if (held_count != 0) begin
                words[k] = close_tuple();
                k++;
            end
        end
        else if (o == OP_SAMPLE) begin
            hit = find_slot(scan_pos, id);
            // a time change or no match past the scan position ends the tuple
            if (held_count != 0 && (hit >= SLOTS || ts != tuple_time)) begin
                words[k] = close_tuple();
                k++;
                hit = find_slot(0, id);
            end
            if (hit >= SLOTS) begin
                words[k] = make_word(KIND_DROP, ts, id, '0, '0, '0, '0);
                k++;
            end
            else begin
                if (held_count == 0)
                    tuple_time = ts;
                held_mask[hit] = 1'b1;
                held_count     = held_count + 1'b1;
                words[k] = make_word(KIND_VALUE, tuple_time, id, val, SLOT_W'(hit), '0, '0);
                k++;
                scan_pos = hit + 1;
                if (scan_pos >= slots_in_use()) begin
                    words[k] = close_tuple();
                    k++;
                end
            end
        end
        if (k > 0)
            words[k-1].last = 1'b1;
        for (int i = 0; i < k; i++)
            expected_words.push_back(words[i]);
    endtask

    task automatic check_word();
        res_t want;
        logic bad;
        if (expected_words.size() == 0) begin
            fail_count++;
            if (fail_count <= SHOW_LIMIT)
                $display("%0t: unexpected word kind %0d time %h id %h", $realtime, kind,
                         time_out, id_out);
        end
        else begin
            want = expected_words.pop_front();
            bad  = (want.kind !== kind) || (want.time_out !== time_out)
                || (want.id_out !== id_out) || (want.value_out !== value_out)
                || (want.slot_out !== slot_out) || (want.presence_mask !== presence_mask)
                || (want.value_count !== value_count) || (want.last !== last);
            if (bad) begin
                fail_count++;
                if (fail_count <= SHOW_LIMIT) begin
                    $display("%0t: mismatch exp kind %0d time %h id %h val %h slot %0d",
                             $realtime, want.kind, want.time_out, want.id_out,
                             want.value_out, want.slot_out);
                    $display("    exp mask %h cnt %0d last %0d", want.presence_mask,
                             want.value_count, want.last);
                    $display("    got kind %0d time %h id %h val %h slot %0d", kind,
                             time_out, id_out, value_out, slot_out);
                    $display("    got mask %h cnt %0d last %0d", presence_mask,
                             value_count, last);
                end
            end
            case (want.kind)
                KIND_VALUE:  value_words++;
                KIND_HEADER: header_words++;
                default:     drop_words++;
            endcase
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            num_series    = NUM_SERIES_RST;
            out_series_id = '0;
            scan_pos      = 0;
            held_count    = '0;
            held_mask     = '0;
            tuple_time    = '0;
            expected_words.delete();
            fail_count    = 0;
            value_words   = 0;
            header_words  = 0;
            drop_words    = 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_NUM_SERIES)
                    num_series = cfg_data[SLOT_W-1:0];
                else
                    out_series_id = cfg_data;
            end
            // results cannot leave on the edge that takes their input word
            if (pop && !empty)
                check_word();
            if (push && !full)
                predict_tuple_words(op, series_id, timestamp, value_bits, slot);
        end
        pending_words = expected_words.size();
    end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Top of the series_tuple_join bench: clock, reset, register writes, input
// words in random bursts and a result side that stalls on its own pattern.
// A directed pass covers the corner cases, then random phases build tuples
// over several slot counts and output ids; the checker does the comparing.
// ----------------------------------------------------------------------------
module tb;
    import stj_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                SLOTS          = MAX_SERIES_DEF;
    localparam int                PHASES         = 7;
    localparam int                PHASE_ITEMS    = 30;
    localparam int                DRAIN_PAUSE    = 200;
    localparam int                HOLD_CYCLES    = 400;
    localparam int                WATCHDOG_LIMIT = 20000;
    localparam logic [OP_W-1:0]   OP_UNUSED      = 2'd3;
    localparam logic [ID_W-1:0]   ALL_ONES       = '1;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 push;
    logic                 full;
    logic [OP_W-1:0]      op;
    logic [ID_W-1:0]      series_id;
    logic [TS_W-1:0]      timestamp;
    logic [VAL_W-1:0]     value_bits;
    logic [SLOT_W-1:0]    slot;
    logic                 empty;
    logic                 pop;
    logic [KIND_W-1:0]    kind;
    logic [TS_W-1:0]      time_out;
    logic [ID_W-1:0]      id_out;
    logic [VAL_W-1:0]     value_out;
    logic [SLOT_W-1:0]    slot_out;
    logic [MASK_W-1:0]    presence_mask;
    logic [CNT_W-1:0]     value_count;
    logic                 last;

    int fail_count;
    int pending_words;
    int value_words;
    int header_words;
    int drop_words;

    // stimulus-side copy of the slot table and slot count
    logic [ID_W-1:0]   tb_ids [SLOTS];
    logic [SLOT_W-1:0] num_shadow;
    logic [TS_W-1:0]   ts_base;
    int                burst_left;
    int                items_sent;
    int                settings;
    int                hold_asked;
    int                hold_served;
    int                idle_run;

    series_tuple_join u_top (.*);

    tuple_join_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int tb_in_use();
        return (num_shadow > SLOTS) ? SLOTS : int'(num_shadow);
    endfunction

    task automatic send_word(input logic [OP_W-1:0] o, input logic [ID_W-1:0] id,
                             input logic [TS_W-1:0] ts, input logic [VAL_W-1:0] val,
                             input logic [SLOT_W-1:0] sl);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        if (o == OP_WRITE && sl < SLOTS)
            tb_ids[sl] = id;
        if (o != OP_UNUSED && !(o == OP_WRITE && sl >= SLOTS))
            items_sent++;
        push       <= 1'b1;
        op         <= o;
        series_id  <= id;
        timestamp  <= ts;
        value_bits <= val;
        slot       <= sl;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        if (idx == CFG_NUM_SERIES)
        begin
            num_shadow = data[SLOT_W-1:0];
            settings++;
        end
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // hold input until every expected word is out, then let the back end settle
    task automatic drain();
        push <= 1'b0;
        do
            @(posedge clk);
        while (pending_words != 0);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    // samples of one time stamp over the slots in ascending order
    task automatic send_tuple();
        int span;
        int first;
        int density;
        span    = (tb_in_use() == 0) ? 4 : tb_in_use();
        first   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span - 1) : 0;
        density = $urandom_range(1, 4);
        case ($urandom_range(0, 9))
            0:       ts_base = rand64();
            1:       ts_base = ALL_ONES;
            2:       ts_base = ts_base;
            default: ts_base = ts_base + $urandom_range(1, 1000);
        endcase
        for (int s = first; s < span; s++)
            if ($urandom_range(0, 3) < density)
                send_word(OP_SAMPLE, tb_ids[s], ts_base, rand64(), SLOT_W'($urandom));
    endtask

    task automatic send_noise();
        int pick;
        pick = $urandom_range(0, SLOTS - 1);
        case ($urandom_range(0, 9))
            0, 1: send_word(OP_SAMPLE, rand64(), rand64(), rand64(), SLOT_W'($urandom));
            2:    send_word(OP_SAMPLE, tb_ids[pick], rand64(), rand64(), SLOT_W'($urandom));
            3:    send_word(OP_FLUSH, rand64(), rand64(), rand64(), SLOT_W'($urandom));
            4:    send_word(OP_UNUSED, rand64(), rand64(), rand64(), SLOT_W'($urandom));
            5:    send_word(OP_WRITE, rand64(), rand64(), rand64(),
                            SLOT_W'($urandom_range(SLOTS, 63)));
            6:    send_word(OP_WRITE, rand64(), rand64(), rand64(),
                            SLOT_W'($urandom_range(0, SLOTS - 1)));
            7:    send_word(OP_WRITE, tb_ids[pick], rand64(), rand64(),
                            SLOT_W'($urandom_range(0, SLOTS - 1)));
            default: send_word(OP_SAMPLE, tb_ids[$urandom_range(0, 3)], ts_base, rand64(),
                               SLOT_W'($urandom));
        endcase
    endtask

    // result side: random stall modes, plus long holds on request
    initial
    begin
        int rx_mode;
        int rx_left;
        rx_mode = 0;
        rx_left = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served < hold_asked)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served++;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = $urandom_range(0, 4);
                    rx_left = (rx_mode == 4) ? $urandom_range(1, 20) : $urandom_range(16, 96);
                end
                rx_left--;
                case (rx_mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    2:       pop <= ($urandom_range(0, 3) == 0);
                    3:       pop <= ($urandom_range(0, 3) != 0);
                    default: pop <= 1'b0;
                endcase
            end
        end
    end

    // end the run when nothing moves for too long
    initial
    begin
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || cfg_we)
                idle_run = 0;
            else
                idle_run++;
        end
        $display("series_tuple_join test failed");
        $finish;
    end

    initial
    begin
        logic [ID_W-1:0] id;
        logic [CFG_W-1:0] out_id;
        logic [CFG_W-1:0] count;
        int phase_start;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        push        <= 1'b0;
        op          <= OP_SAMPLE;
        series_id   <= '0;
        timestamp   <= '0;
        value_bits  <= '0;
        slot        <= '0;
        num_shadow  = NUM_SERIES_RST;
        ts_base     = '0;
        burst_left  = 0;
        items_sent  = 0;
        settings    = 0;
        hold_asked  = 0;
        hold_served = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole slot table before any sample scans it
        for (int s = 0; s < SLOTS; s++)
        begin
            if (s == 0)
                id = '0;
            else if (s == 1)
                id = ALL_ONES;
            else if ($urandom_range(0, 4) == 0)
                id = tb_ids[$urandom_range(0, s - 1)];
            else
                id = rand64();
            send_word(OP_WRITE, id, rand64(), rand64(), SLOT_W'(s));
        end
        drain();

        write_reg(CFG_NUM_SERIES, 4);
        write_reg(CFG_OUT_ID, ALL_ONES);
        send_word(OP_SAMPLE, tb_ids[0], '0, '0, '0);
        send_word(OP_SAMPLE, tb_ids[1], '0, ALL_ONES, '1);
        send_word(OP_SAMPLE, tb_ids[2], ALL_ONES, rand64(), '0);   // time change
        send_word(OP_FLUSH, rand64(), rand64(), rand64(), SLOT_W'($urandom));
        send_word(OP_FLUSH, rand64(), rand64(), rand64(), SLOT_W'($urandom)); // nothing held
        send_word(OP_UNUSED, rand64(), rand64(), rand64(), SLOT_W'($urandom));
        send_word(OP_WRITE, rand64(), rand64(), rand64(), 6'd63);  // out of range
        send_word(OP_WRITE, rand64(), rand64(), rand64(), 6'd3);
        send_word(OP_SAMPLE, rand64(), rand64(), rand64(), '0);    // matches nothing
        send_word(OP_SAMPLE, tb_ids[2], 64'd5, rand64(), '0);
        send_word(OP_SAMPLE, tb_ids[0], 64'd5, rand64(), '0);      // behind the scan
        for (int s = 1; s < 4; s++)
            send_word(OP_SAMPLE, tb_ids[s], 64'd5, rand64(), '0);  // last slot closes
        for (int s = 0; s < 3; s++)
            send_word(OP_SAMPLE, tb_ids[s], 64'd7, rand64(), '0);
        send_word(OP_SAMPLE, tb_ids[3], 64'd8, rand64(), '0);      // close, value, close
        send_word(OP_SAMPLE, tb_ids[0], 64'd9, rand64(), '0);
        send_word(OP_SAMPLE, tb_ids[1], 64'd9, rand64(), '0);
        drain();
        // scan position now lies past the end of the slots in use
        write_reg(CFG_NUM_SERIES, 1);
        send_word(OP_SAMPLE, tb_ids[0], 64'd9, rand64(), '0);
        drain();
        write_reg(CFG_NUM_SERIES, 0);
        send_word(OP_SAMPLE, tb_ids[0], 64'd10, rand64(), '0);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0:
                begin
                    count  = 58;
                    out_id = ALL_ONES;
                end
                1:
                begin
                    count  = 0;
                    out_id = rand64();
                end
                2:
                begin
                    count  = 63;
                    out_id = '0;
                end
                3:
                begin
                    count  = 3;
                    out_id = rand64();
                end
                4:
                begin
                    count  = 1;
                    out_id = rand64();
                end
                5:
                begin
                    count  = $urandom_range(2, 57);
                    out_id = rand64();
                end
                default:
                begin
                    count  = 58;
                    out_id = rand64();
                end
            endcase
            write_reg(CFG_NUM_SERIES, count);
            write_reg(CFG_OUT_ID, out_id);
            // back up the block while the sender keeps offering words
            if (p == 0 || p == 3)
                hold_asked++;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 7)
                    send_tuple();
                else
                    send_noise();
            end
        end
        drain();

        $display("sent %0d input words over %0d slot count settings", items_sent, settings);
        $display("checked %0d values, %0d headers and %0d dropped samples",
                 value_words, header_words, drop_words);
        if (fail_count == 0)
            $display("series_tuple_join test passed");
        else
            $display("series_tuple_join test failed");
        $finish;
    end

endmodule
